/* hw/rtl/tccw_pkg.sv */
// shared types and constants of the text console character writer
package tccw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_CLEAR     = 8'h03;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_EXEC  = 6'b000100,
    S_CLEAR = 6'b001000,
    S_BLANK = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic sweep_clear;
    logic sweep_blank;
  } cmd_t;

  typedef struct packed {
    logic is_read;
    logic is_clear;
    logic scroll;
    logic sweep_last;
  } sts_t;

endpackage

/* hw/rtl/tccw_ctrl.sv */
// control state machine of the text console character writer
module tccw_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  tccw_pkg::sts_t sts,
  output tccw_pkg::cmd_t cmd,
  output logic          busy,
  output logic          done
);
  import tccw_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    cmd             = '0;
    case (state)
      S_INIT: begin
        cmd.sweep_clear = 1'b1;
        if (sts.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.is_read) begin
          state_next = S_DONE;
        end else if (sts.is_clear) begin
          state_next = S_CLEAR;
        end else if (sts.scroll) begin
          state_next = S_BLANK;
        end else begin
          state_next = S_DONE;
        end
      end
      S_CLEAR: begin
        cmd.sweep_clear = 1'b1;
        if (sts.sweep_last) begin
          state_next = S_DONE;
        end
      end
      S_BLANK: begin
        cmd.sweep_blank = 1'b1;
        if (sts.sweep_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

/* hw/rtl/tccw_dp.sv */
// datapath of the text console character writer: screen store, cursor, row offset
module tccw_dp #(
  parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  tccw_pkg::cmd_t cmd,
  output tccw_pkg::sts_t sts,
  input  logic           opcode,
  input  logic [7:0]     char_code,
  input  logic [4:0]     read_row,
  input  logic [6:0]     read_col,
  output logic [7:0]     cell_value,
  output logic [6:0]     cursor_column,
  output logic [4:0]     cursor_line
);
  import tccw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);

  logic [7:0]    mem [CELLS];
  logic [7:0]    rdata;

  logic          op;
  logic [7:0]    ch;
  logic [4:0]    rrow;
  logic [6:0]    rcol;

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [RW-1:0] top;
  logic [AW-1:0] blank_base;
  logic [AW-1:0] cnt;

  logic          is_nl;
  logic          is_clr;
  logic          is_bs;
  logic          is_put;
  logic          in_range;
  logic          wr_char;
  logic [CW:0]   col_a;
  logic [RW:0]   row_a;
  logic [RW:0]   row_b;
  logic [CW:0]   col_b;
  logic [CW-1:0] wr_col;
  logic [AW-1:0] put_addr;
  logic [AW-1:0] rd_addr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;

  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] lr, input logic [RW-1:0] t);
    logic [RW:0] s;
    s = {1'b0, lr} + {1'b0, t};
    if (s >= (RW+1)'(ROWS)) begin
      s = s - (RW+1)'(ROWS);
    end
    return s[RW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op   <= opcode;
      ch   <= char_code;
      rrow <= read_row;
      rcol <= read_col;
    end
  end

  assign is_put   = (op == OP_PUT);
  assign is_nl    = is_put && (ch == CH_NEWLINE);
  assign is_clr   = is_put && (ch == CH_CLEAR);
  assign is_bs    = is_put && (ch == CH_BACKSPACE);
  assign in_range = (32'(rrow) < ROWS) && (32'(rcol) < COLUMNS);
  assign wr_char  = is_put && !is_nl && !is_clr && !is_bs;

  always_comb begin
    col_a  = {1'b0, col};
    row_a  = {1'b0, row};
    wr_col = col;
    if (is_nl) begin
      col_a = '0;
      row_a = {1'b0, row} + 1'b1;
    end else if (is_bs) begin
      if (col != '0) begin
        col_a  = {1'b0, col} - 1'b1;
        wr_col = col - 1'b1;
      end
    end else if (wr_char) begin
      col_a = {1'b0, col} + 1'b1;
    end
    col_b = col_a;
    row_b = row_a;
    if (col_a >= (CW+1)'(COLUMNS)) begin
      col_b = '0;
      row_b = row_a + 1'b1;
    end
  end

  assign put_addr = AW'(AW'(phys_row(row, top)) * AW'(COLUMNS)) + AW'(wr_col);
  assign rd_addr  = AW'(AW'(phys_row(RW'(rrow), top)) * AW'(COLUMNS)) + AW'(rcol);

  assign sts.is_read    = !is_put;
  assign sts.is_clear   = is_clr;
  assign sts.scroll     = is_put && !is_clr && (row_b >= (RW+1)'(ROWS));
  assign sts.sweep_last = cmd.sweep_blank ? (cnt == AW'(COLUMNS - 1))
                                          : (cnt == AW'(CELLS - 1));

  always_comb begin
    we    = 1'b0;
    waddr = put_addr;
    wdata = ch;
    if (cmd.sweep_clear) begin
      we    = 1'b1;
      waddr = cnt;
      wdata = '0;
    end else if (cmd.sweep_blank) begin
      we    = 1'b1;
      waddr = blank_base + cnt;
      wdata = '0;
    end else if (cmd.exec && wr_char) begin
      we = 1'b1;
    end else if (cmd.exec && is_bs && (col != '0)) begin
      we    = 1'b1;
      wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.exec && !is_put) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      top <= '0;
      cnt <= '0;
    end else begin
      cnt <= (cmd.sweep_clear || cmd.sweep_blank) ? cnt + 1'b1 : '0;
      if (cmd.exec && is_put) begin
        if (is_clr) begin
          col <= '0;
          row <= '0;
          top <= '0;
        end else if (sts.scroll) begin
          col <= '0;
          row <= RW'(ROWS - 1);
          top <= (top == RW'(ROWS - 1)) ? '0 : top + 1'b1;
        end else begin
          col <= col_b[CW-1:0];
          row <= row_b[RW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      blank_base <= AW'(AW'(top) * AW'(COLUMNS));
    end
  end

  assign cell_value    = (!is_put && in_range) ? rdata : '0;
  assign cursor_column = 7'(col);
  assign cursor_line   = 5'(row);

endmodule

/* hw/rtl/text_console_char_writer.sv */
// top level of the text console character writer
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------------
//  item in  | start, busy         | opcode, char_code, read_row, read_col
//  result   | done (one cycle)    | cell_value, cursor_column, cursor_line
//
// a read or a plain put passes from accept through S_EXEC to S_DONE,
// where it raises done, and the next item is taken in S_IDLE; a put that
// scrolls also passes S_BLANK to blank the new bottom row (rows sit in a
// circular row order, so no cells are moved); a clear passes S_CLEAR to
// sweep the store, one store write per cycle. after reset busy stays high
// while the store is swept to zero. results cannot be stalled: each is
// shown for the single cycle that done is high.
module text_console_char_writer #(
  parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       opcode,
  input  logic [7:0] char_code,
  input  logic [4:0] read_row,
  input  logic [6:0] read_col,
  output logic       done,
  output logic [7:0] cell_value,
  output logic [6:0] cursor_column,
  output logic [4:0] cursor_line
);
  import tccw_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tccw_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  tccw_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .opcode        (opcode),
    .char_code     (char_code),
    .read_row      (read_row),
    .read_col      (read_col),
    .cell_value    (cell_value),
    .cursor_column (cursor_column),
    .cursor_line   (cursor_line)
  );

endmodule

/* tb/sv/tb_top.sv */
// self-checking testbench for the text console character writer, screen mirrored in a scoreboard
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tccw_pkg::*;

  localparam int COLS = COLUMNS_DEF;
  localparam int ROWS = ROWS_DEF;
  localparam int ITEM_TARGET = 1350;
  localparam int CYCLE_LIMIT = 15_000_000;
  localparam int TAIL_CYCLES = 8;

  typedef struct packed {
    logic [7:0] value;
    logic [6:0] column;
    logic [4:0] row_no;
  } cell_report_t;

  class screen_mirror;
    logic [7:0] cells [ROWS][COLS];
    int unsigned cur_col;
    int unsigned cur_row;
    cell_report_t expected_reports[$];
    int unsigned mismatches;

    function new();
      clear_screen();
      cur_col = 0;
      cur_row = 0;
      mismatches = 0;
    endfunction

    function void clear_screen();
      foreach (cells[r, c]) cells[r][c] = 8'h00;
    endfunction

    function void scroll_up();
      for (int r = 0; r < ROWS - 1; r++) begin
        for (int c = 0; c < COLS; c++) cells[r][c] = cells[r + 1][c];
      end
      for (int c = 0; c < COLS; c++) cells[ROWS - 1][c] = 8'h00;
    endfunction

    function void apply_item(logic op, logic [7:0] ch, logic [4:0] rrow, logic [6:0] rcol);
      cell_report_t rep;
      rep.value = 8'h00;
      if (op == OP_PUT) begin
        if (ch == CH_NEWLINE) begin
          cur_col = 0;
          cur_row++;
        end else if (ch == CH_CLEAR) begin
          cur_col = 0;
          cur_row = 0;
          clear_screen();
        end else if (ch == CH_BACKSPACE) begin
          if (cur_col > 0) begin
            cur_col--;
            cells[cur_row][cur_col] = 8'h00;
          end
        end else begin
          cells[cur_row][cur_col] = ch;
          cur_col++;
        end
        if (cur_col >= COLS) begin
          cur_col = 0;
          cur_row++;
        end
        if (cur_row >= ROWS) begin
          scroll_up();
          cur_col = 0;
          cur_row = ROWS - 1;
        end
      end else if (rrow < ROWS && rcol < COLS) begin
        rep.value = cells[rrow][rcol];
      end
      rep.column = cur_col[6:0];
      rep.row_no = cur_row[4:0];
      expected_reports.push_back(rep);
    endfunction

    function void check_report(logic [7:0] value, logic [6:0] column, logic [4:0] row_no);
      cell_report_t want;
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %h column %0d row %0d", value, column, row_no);
        return;
      end
      want = expected_reports.pop_front();
      if (want.value !== value || want.column !== column || want.row_no !== row_no) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected value %h column %0d row %0d, got value %h column %0d row %0d",
                   want.value, want.column, want.row_no, value, column, row_no);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic       opcode = OP_PUT;
  logic [7:0] char_code = 8'h00;
  logic [4:0] read_row = 5'd0;
  logic [6:0] read_col = 7'd0;
  logic       done;
  logic [7:0] cell_value;
  logic [6:0] cursor_column;
  logic [4:0] cursor_line;

  screen_mirror mirror = new();
  int unsigned  idle_pct = 0;
  int unsigned  items_sent = 0;
  int unsigned  cycle_count = 0;

  text_console_char_writer dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .opcode        (opcode),
    .char_code     (char_code),
    .read_row      (read_row),
    .read_col      (read_col),
    .done          (done),
    .cell_value    (cell_value),
    .cursor_column (cursor_column),
    .cursor_line   (cursor_line)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) mirror.check_report(cell_value, cursor_column, cursor_line);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // one beat: hold start until accepted, then maybe leave a gap
  task automatic send_item(input logic op, input logic [7:0] ch,
                           input logic [4:0] rrow, input logic [6:0] rcol);
    start     <= 1'b1;
    opcode    <= op;
    char_code <= ch;
    read_row  <= rrow;
    read_col  <= rcol;
    do @(posedge clk); while (busy);
    mirror.apply_item(op, ch, rrow, rcol);
    items_sent++;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic put_char(input logic [7:0] ch);
    send_item(OP_PUT, ch, 5'($urandom_range(31)), 7'($urandom_range(127)));
  endtask

  task automatic read_cell(input logic [4:0] rrow, input logic [6:0] rcol);
    send_item(OP_READ, 8'($urandom_range(255)), rrow, rcol);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    if (c == CH_NEWLINE || c == CH_CLEAR || c == CH_BACKSPACE) c = c ^ 8'h40;
    return c;
  endfunction

  initial begin
    int unsigned kind;
    int unsigned len;
    int unsigned band;
    int unsigned r;
    int unsigned phase;
    int unsigned idle_steps [4];
    idle_steps = '{0, 83, 0, 19};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: edges of the screen, out-of-range reads, every control byte
    read_cell(5'd0, 7'd0);
    read_cell(5'(ROWS - 1), 7'(COLS - 1));
    read_cell(5'(ROWS - 1), 7'd0);
    read_cell(5'(ROWS), 7'd0);
    read_cell(5'd0, 7'(COLS));
    read_cell(5'd31, 7'd127);
    put_char(8'h00);
    put_char(8'hFF);
    put_char(8'h7F);
    put_char(8'h80);
    read_cell(5'd0, 7'd1);
    read_cell(5'd0, 7'd3);
    repeat (5) put_char(CH_BACKSPACE);
    put_char(CH_NEWLINE);
    put_char(8'h41);
    read_cell(5'd1, 7'd0);
    put_char(CH_CLEAR);
    read_cell(5'd1, 7'd0);
    put_char(CH_BACKSPACE);

    // random: mostly text lines, newline runs and reads near the cursor
    while (items_sent < ITEM_TARGET) begin
      phase = (items_sent / 150) % 4;
      idle_pct = idle_steps[phase];
      kind = $urandom_range(99);
      if (kind < 40) begin
        band = $urandom_range(9);
        if (band < 4) len = $urandom_range(6);
        else if (band < 8) len = $urandom_range(40, 7);
        else len = $urandom_range(100, 70);
        repeat (len) put_char(plain_byte());
        if ($urandom_range(9) < 6) put_char(CH_NEWLINE);
      end else if (kind < 55) begin
        repeat ($urandom_range(30, 1)) put_char(CH_NEWLINE);
      end else if (kind < 75) begin
        repeat ($urandom_range(6, 1)) begin
          if ($urandom_range(9) < 7) begin
            r = mirror.cur_row;
            if ($urandom_range(1) && r > 0) r--;
            read_cell(5'(r), 7'($urandom_range(COLS - 1)));
          end else begin
            read_cell(5'($urandom_range(31)), 7'($urandom_range(127)));
          end
        end
      end else if (kind < 85) begin
        repeat ($urandom_range(10, 1)) begin
          if ($urandom_range(3) == 0) put_char(plain_byte());
          else put_char(CH_BACKSPACE);
        end
      end else if (kind < 98) begin
        repeat ($urandom_range(8, 1))
          send_item(1'($urandom_range(1)), 8'($urandom_range(255)),
                    5'($urandom_range(31)), 7'($urandom_range(127)));
      end else begin
        put_char(CH_CLEAR);
      end
    end

    start <= 1'b0;
    while (mirror.expected_reports.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mirror.mismatches == 0 && mirror.expected_reports.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
